[rtl/core/nlsru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NLS row update package
// Shared constants and types for the explicit nonlinear Schroedinger row update.
// ----------------------------------------------------------------------------
package nlsru_pkg;

  // Fixed-point format: all values carry this many fraction bits.
  localparam int FRAC_BITS = 13;

  // Default width of one sample component.
  localparam int SAMPLE_WIDTH_DEF = 18;

  // Configuration port.
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 18;
  localparam int UCOEF_WIDTH     = 17;
  localparam int SCOEF_WIDTH     = 18;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  typedef logic [CFG_DATA_WIDTH-1:0]  cfg_data_t;

  // Register indexes.
  localparam cfg_index_t REG_TIME_STEP    = 2'd0;
  localparam cfg_index_t REG_LAPLACIAN    = 2'd1;
  localparam cfg_index_t REG_POTENTIAL    = 2'd2;
  localparam cfg_index_t REG_NONLINEARITY = 2'd3;

  // Register reset values.
  localparam logic [UCOEF_WIDTH-1:0] TIME_STEP_RST    = 17'd82;
  localparam logic [UCOEF_WIDTH-1:0] LAPLACIAN_RST    = 17'd512;
  localparam logic [SCOEF_WIDTH-1:0] POTENTIAL_RST    = 18'd0;
  localparam logic [SCOEF_WIDTH-1:0] NONLINEARITY_RST = 18'd0;

  // Position inside a row.
  typedef logic [1:0] row_pos_t;
  localparam row_pos_t POS_START = 2'd0;
  localparam row_pos_t POS_ONE   = 2'd1;
  localparam row_pos_t POS_MANY  = 2'd2;

endpackage

[rtl/core/nls_explicit_row_update_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NLS explicit row update
// Streams one time row of a complex wave function and emits the next time row
// of an explicit Euler step of the nonlinear Schroedinger equation.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+---------------------------------------
//  input   | in_valid / in_stall    | psi_re, psi_im, row_end
//  output  | out_valid / out_stall  | new_re, new_im, row_done
//  config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each result is computed by one shared signed multiplier under a step
// sequencer that runs from the start of a result to its load into the
// output register; the squaring, nonlinearity, time step, scaling and
// Laplacian steps issue products. An item that only fills the window gives
// no result, any other item gives one, and an item that closes a row of two
// or more points gives two. The block takes a new item in the cycle after
// its last result is loaded, even while that result still waits on out_stall.
// The sequencer holds at its final step while the output register is full
// and stalled. Reset is synchronous and restores the register defaults, an
// empty output and the row-start position. Config writes are always taken.
//
module nls_explicit_row_update_top #(
  parameter int SAMPLE_WIDTH = nlsru_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input items.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]     psi_re,
  input  logic signed [SAMPLE_WIDTH-1:0]     psi_im,
  input  logic                               row_end,
  // Result items.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]     new_re,
  output logic signed [SAMPLE_WIDTH-1:0]     new_im,
  output logic                               row_done,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  nlsru_pkg::cfg_index_t              cfg_index,
  input  nlsru_pkg::cfg_data_t               cfg_data
);

  import nlsru_pkg::*;

  // Widths: the Laplacian needs two guard bits, the multiplier operands must
  // also hold the 18-bit coefficients, and the extended width takes any sum
  // of two products with room for rounding.
  localparam int W  = SAMPLE_WIDTH;
  localparam int LW = W + 2;
  localparam int MW = (LW > SCOEF_WIDTH) ? LW : SCOEF_WIDTH;
  localparam int PW = 2 * MW;
  localparam int EW = PW + 1;

  localparam longint SMAX = (longint'(1) << (W - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam logic signed [EW-1:0] SAT_HI = EW'(SMAX);
  localparam logic signed [EW-1:0] SAT_LO = EW'(SMIN);
  localparam logic signed [EW-1:0] HALF   = EW'(2 ** (FRAC_BITS - 1));

  // Sequencer steps. Each step names what the shared multiplier works on or
  // which rounded product is captured.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQ_RE = 4'd1;   // re*re
  localparam logic [3:0] ST_SQ_IM = 4'd2;   // im*im, keep re*re
  localparam logic [3:0] ST_MAG   = 4'd3;   // |psi|^2
  localparam logic [3:0] ST_NL    = 4'd4;   // alpha*|psi|^2
  localparam logic [3:0] ST_POT   = 4'd5;   // g = U + n
  localparam logic [3:0] ST_DT    = 4'd6;   // dt*g
  localparam logic [3:0] ST_F     = 4'd7;   // capture f
  localparam logic [3:0] ST_S_RE  = 4'd8;   // f*re
  localparam logic [3:0] ST_S_IM  = 4'd9;   // f*im, capture s_re
  localparam logic [3:0] ST_L_RE  = 4'd10;  // k*lap_re, capture s_im
  localparam logic [3:0] ST_L_IM  = 4'd11;  // k*lap_im, capture l_re
  localparam logic [3:0] ST_SUM   = 4'd12;  // capture l_im
  localparam logic [3:0] ST_OUT   = 4'd13;  // combine and load the output

  function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r[W-1:0];
  endfunction

  // Round half up at the binary point, then saturate.
  function automatic logic signed [W-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [EW-1:0] t;
    t = (EW'(p) + HALF) >>> FRAC_BITS;
    return sat_w(t);
  endfunction

  // Configuration registers.
  logic        [UCOEF_WIDTH-1:0] time_step;
  logic        [UCOEF_WIDTH-1:0] laplacian_coefficient;
  logic signed [SCOEF_WIDTH-1:0] potential;
  logic signed [SCOEF_WIDTH-1:0] nonlinearity;

  // Three-point window and row tracking.
  logic signed [W-1:0] left_re, left_im;
  logic signed [W-1:0] center_re, center_im;
  logic signed [W-1:0] right_re, right_im;
  row_pos_t            row_position;

  // Job flags: end point, last of row, and a second result still to come.
  logic job_edge;
  logic job_done;
  logic job_second;

  logic [3:0] state;

  // Datapath registers.
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] acc;
  logic signed [W-1:0]  m, g, f, s_re, s_im, l_re, l_im;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [LW-1:0] lap_re, lap_im;
  logic signed [EW-1:0] mag_sum;
  logic signed [EW-1:0] pot_sum;
  logic signed [EW-1:0] sum_re, sum_im;
  logic                 in_take;
  logic                 out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !(out_valid && out_stall);

  // The end points of a row skip the Laplacian term: with a zero operand the
  // rounded product is zero as well.
  always_comb begin
    if (job_edge) begin
      lap_re = '0;
      lap_im = '0;
    end else begin
      lap_re = LW'(left_re) - (LW'(center_re) <<< 1) + LW'(right_re);
      lap_im = LW'(left_im) - (LW'(center_im) <<< 1) + LW'(right_im);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      ST_SQ_RE: begin
        mul_a = MW'(center_re);
        mul_b = MW'(center_re);
      end
      ST_SQ_IM: begin
        mul_a = MW'(center_im);
        mul_b = MW'(center_im);
      end
      ST_NL: begin
        mul_a = MW'(nonlinearity);
        mul_b = MW'(m);
      end
      ST_DT: begin
        mul_a = MW'(time_step);
        mul_b = MW'(g);
      end
      ST_S_RE: begin
        mul_a = MW'(f);
        mul_b = MW'(center_re);
      end
      ST_S_IM: begin
        mul_a = MW'(f);
        mul_b = MW'(center_im);
      end
      ST_L_RE: begin
        mul_a = MW'(laplacian_coefficient);
        mul_b = MW'(lap_re);
      end
      ST_L_IM: begin
        mul_a = MW'(laplacian_coefficient);
        mul_b = MW'(lap_im);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The squared magnitude is rounded once, after both squares are summed.
  assign mag_sum = (EW'(acc) + EW'(prod) + HALF) >>> FRAC_BITS;
  assign pot_sum = EW'(potential) + EW'(rnd(prod));
  assign sum_re  = EW'(center_re) + EW'(s_im) - EW'(l_im);
  assign sum_im  = EW'(center_im) - EW'(s_re) + EW'(l_re);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_SQ_IM: acc  <= prod;
      ST_MAG:   m    <= sat_w(mag_sum);
      ST_POT:   g    <= sat_w(pot_sum);
      ST_F:     f    <= rnd(prod);
      ST_S_IM:  s_re <= rnd(prod);
      ST_L_RE:  s_im <= rnd(prod);
      ST_L_IM:  l_re <= rnd(prod);
      ST_SUM:   l_im <= rnd(prod);
      default: begin
      end
    endcase
  end

  // Configuration writes keep only each register's own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step             <= TIME_STEP_RST;
      laplacian_coefficient <= LAPLACIAN_RST;
      potential             <= POTENTIAL_RST;
      nonlinearity          <= NONLINEARITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIME_STEP:    time_step             <= cfg_data[UCOEF_WIDTH-1:0];
        REG_LAPLACIAN:    laplacian_coefficient <= cfg_data[UCOEF_WIDTH-1:0];
        REG_POTENTIAL:    potential             <= cfg_data[SCOEF_WIDTH-1:0];
        REG_NONLINEARITY: nonlinearity          <= cfg_data[SCOEF_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, window and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      row_position <= POS_START;
      out_valid    <= 1'b0;
      job_edge     <= 1'b0;
      job_done     <= 1'b0;
      job_second   <= 1'b0;
    end else begin
      // The final step reloads the output itself when it is free.
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            case (row_position)
              POS_START: begin
                // The first point only fills the window, unless it is the
                // whole row.
                center_re <= psi_re;
                center_im <= psi_im;
                if (row_end) begin
                  job_edge   <= 1'b1;
                  job_done   <= 1'b1;
                  job_second <= 1'b0;
                  state      <= ST_SQ_RE;
                end else begin
                  row_position <= POS_ONE;
                end
              end
              default: begin
                // The held center is finished now; a row end also finishes
                // the new point as the right end of the row.
                right_re     <= psi_re;
                right_im     <= psi_im;
                job_edge     <= (row_position == POS_ONE);
                job_done     <= 1'b0;
                job_second   <= row_end;
                row_position <= row_end ? POS_START : POS_MANY;
                state        <= ST_SQ_RE;
              end
            endcase
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            new_re    <= sat_w(sum_re);
            new_im    <= sat_w(sum_im);
            row_done  <= job_done;
            left_re   <= center_re;
            left_im   <= center_im;
            center_re <= right_re;
            center_im <= right_im;
            if (job_second) begin
              job_edge   <= 1'b1;
              job_done   <= 1'b1;
              job_second <= 1'b0;
              state      <= ST_SQ_RE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= state + 4'd1;
        end
      endcase
    end
  end

  // The squared magnitude never goes negative.
  a_mag_nonneg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NL) |-> !m[W-1])
    else $error("squared magnitude is negative");

  // An end point carries no Laplacian term in its real part.
  a_edge_no_lap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM && job_edge) |-> (l_re == '0))
    else $error("end point picked up a Laplacian term");

  // A pending second result is never flagged as the row's last.
  a_second_not_done: assert property (@(posedge clk) disable iff (rst)
    job_second |-> !job_done)
    else $error("first of two results marked as row end");

  // A result is loaded only from the final step.
  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_OUT))
    else $error("output loaded outside the final step");

  // Reset leaves the block idle with an empty output.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (state == ST_IDLE && !out_valid))
    else $error("block not idle after reset");

endmodule
